### hdl/fialu_pkg.sv
`default_nettype none
package fialu_pkg;

  localparam int OPD_W = 14;
  localparam int RES_W = 28;
  localparam int CMD_W = 3;
  localparam int CNT_W = $clog2(OPD_W);

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;

  // Largest positive value of the signed result field.
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture a new item
    logic step;   // one shift-add or restoring-divide step
    logic emit;   // move the finished result into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic long_op;  // the incoming command needs the iterative unit
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/fialu_ctrl.sv
`default_nettype none
module fialu_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire fialu_pkg::dp_status_t status,
  output fialu_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [fialu_pkg::CNT_W-1:0] count;
  logic [fialu_pkg::CNT_W-1:0] count_next;
  logic                        out_valid_next;
  logic                        slot_free;
  logic                        last_step;

  // No item is taken while reset is held.
  assign in_stall  = rst || (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign last_step = (count == fialu_pkg::CNT_W'(fialu_pkg::OPD_W - 1));

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          count_next = '0;
          state_next = status.long_op ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (last_step) begin
          state_next = ST_FIN;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### hdl/fialu_dp.sv
`default_nettype none
module fialu_dp (
  input  wire logic                         clk,
  input  wire logic [fialu_pkg::CMD_W-1:0]  command,
  input  wire logic [fialu_pkg::OPD_W-1:0]  operand_a,
  input  wire logic [fialu_pkg::OPD_W-1:0]  operand_b,
  input  wire fialu_pkg::ctrl_cmd_t         cmd,
  output fialu_pkg::dp_status_t             status,
  output logic signed [fialu_pkg::RES_W-1:0] result,
  output logic                              error
);

  localparam int OW = fialu_pkg::OPD_W;
  localparam int RW = fialu_pkg::RES_W;

  logic [fialu_pkg::CMD_W-1:0] cmd_q;
  logic [OW-1:0]               a_q;
  logic [OW-1:0]               b_q;
  // Shared work register: {partial product, multiplier} for multiply,
  // {remainder, dividend/quotient} for divide.
  logic [RW-1:0]               work;
  logic [RW-1:0]               work_next;
  logic [OW:0]                 mul_sum;
  logic [OW:0]                 div_trial;
  logic [OW+1:0]               div_diff;
  logic [RW-1:0]               res_next;
  logic                        err_next;

  assign status.long_op = (command == fialu_pkg::CMD_MUL) || (command == fialu_pkg::CMD_DIV);

  assign mul_sum   = {1'b0, work[RW-1:OW]} + {1'b0, a_q};
  assign div_trial = {work[RW-1:OW], work[OW-1]};
  assign div_diff  = {1'b0, div_trial} - {2'b00, b_q};

  always_comb begin
    work_next = work;
    if (cmd.load) begin
      if (command == fialu_pkg::CMD_MUL) begin
        work_next = {{(RW-OW){1'b0}}, operand_b};
      end else begin
        work_next = {{(RW-OW){1'b0}}, operand_a};
      end
    end else if (cmd.step) begin
      if (cmd_q == fialu_pkg::CMD_MUL) begin
        // Add the multiplicand when the low multiplier bit is set, shift right.
        if (work[0]) begin
          work_next = {mul_sum, work[OW-1:1]};
        end else begin
          work_next = {1'b0, work[RW-1:1]};
        end
      end else begin
        // Restoring step: keep the subtraction when it does not borrow.
        if (!div_diff[OW+1]) begin
          work_next = {div_diff[OW-1:0], work[OW-2:0], 1'b1};
        end else begin
          work_next = {work[RW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    res_next = '0;
    err_next = 1'b0;
    case (cmd_q)
      fialu_pkg::CMD_ADD: begin
        res_next = {{(RW-OW-1){1'b0}}, {1'b0, a_q} + {1'b0, b_q}};
      end
      fialu_pkg::CMD_SUB: begin
        res_next = {{(RW-OW){1'b0}}, a_q} - {{(RW-OW){1'b0}}, b_q};
      end
      fialu_pkg::CMD_MUL: begin
        if (work[RW-1]) begin
          res_next = fialu_pkg::RES_MAX;
        end else begin
          res_next = work;
        end
      end
      fialu_pkg::CMD_DIV: begin
        if (b_q == '0) begin
          err_next = 1'b1;
        end else begin
          res_next = {{(RW-OW){1'b0}}, work[OW-1:0]};
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    work <= work_next;
    if (cmd.load) begin
      cmd_q <= command;
      a_q   <= operand_a;
      b_q   <= operand_b;
    end
    if (cmd.emit) begin
      result <= res_next;
      error  <= err_next;
    end
  end

endmodule
`default_nettype wire

### hdl/four_function_integer_alu_top.sv
`default_nettype none
// Four-function integer ALU. Each input item carries a command (add, subtract,
// multiply, divide) and two unsigned 14-bit operands; each produces exactly one
// result item with a 28-bit two's complement result and an error flag. Add,
// subtract and unknown commands go from acceptance straight to the output
// hand-off. Multiply and divide run 14 steps on a shared shift register (one
// shift-add or restoring-subtract step per cycle) before the hand-off.
// A new item is accepted once the previous result has moved into the output
// register, which holds it until taken; in_stall is high while an item is in
// work. A product above the largest positive result saturates, and a zero
// divisor returns zero with error set.
module four_function_integer_alu_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fialu_pkg::CMD_W-1:0]   command,
  input  wire logic [fialu_pkg::OPD_W-1:0]   operand_a,
  input  wire logic [fialu_pkg::OPD_W-1:0]   operand_b,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [fialu_pkg::RES_W-1:0] result,
  output logic                               error
);

  fialu_pkg::ctrl_cmd_t  cmd;
  fialu_pkg::dp_status_t status;

  // The controller sequences load, the iterative steps and the output hand-off.
  fialu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the shared work register and the
  // output register.
  fialu_dp u_dp (
    .clk       (clk),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .error     (error)
  );

endmodule
`default_nettype wire

### hdl/fialu_chk.sv
`default_nettype none
module fialu_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [fialu_pkg::RES_W-1:0] result,
  input wire logic                          error
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result) && $stable(error))
    else $error("result item changed while stalled");

  // A divide-by-zero error always carries a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> result == '0)
    else $error("error item with nonzero result");

  // Only one item is in work at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // No result appears in the cycle right after an item is taken.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind four_function_integer_alu_top fialu_chk u_fialu_chk (.*);
`default_nettype wire
